// ----- hdl/msbb_pkg.sv -----
// shared constants and types for the masked box blur
package msbb_pkg;
   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int MAX_RADIUS = 15;
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int VAL_W  = 24;
   localparam int CNT_W  = $clog2(2 * MAX_RADIUS + 2);
   localparam int SUM_W  = VAL_W + CNT_W + 1;
   localparam int CSR_W  = 7;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS   = 2'd2;
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic              op;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [VAL_W-1:0]  value;
      logic              valid;
   } req_type;

   // a classified command for the back end
   typedef struct packed {
      logic              is_load;
      logic              is_hole;
      logic [ADDR_W-1:0] addr;
      logic [VAL_W-1:0]  value;
      logic              valid;
      logic [ROW_W-1:0]  r0;
      logic [ROW_W-1:0]  r1;
      logic [COL_W-1:0]  c0;
      logic [COL_W-1:0]  c1;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_COL_DIV, ST_OUT_DIV, ST_SEND
   } back_state_type;

   typedef enum logic [1:0] {
      DV_IDLE, DV_RUN, DV_DONE
   } div_state_type;
endpackage

// ----- hdl/msbb_if.sv -----
// valid/ready channel interfaces
interface msbb_req_if;
   logic                 valid;
   logic                 ready;
   msbb_pkg::req_type    data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface msbb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [msbb_pkg::VAL_W-1:0]  blurred_value;
   logic                        blurred_valid;
   modport source (output valid, output blurred_value, output blurred_valid, input ready);
   modport sink (input valid, input blurred_value, input blurred_valid, output ready);
endinterface

// ----- hdl/msbb_front.sv -----
// front end: clamps configuration, classifies items and computes windows
module msbb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [msbb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [msbb_pkg::CSR_W-1:0]    csr_data,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  msbb_pkg::req_type             in_data,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output msbb_pkg::cmd_type             cmd_data
);
   logic [3:0] radius_ff;
   logic [6:0] rows_ff, cols_ff;
   logic [7:0] rows_c, cols_c;
   logic [7:0] rad_c;
   logic [7:0] lo_r, hi_r, lo_c, hi_c;
   msbb_pkg::cmd_type cmd_ff, cmd_in;
   logic cmd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 4'd1;
         rows_ff   <= 7'd64;
         cols_ff   <= 7'd64;
      end else if (csr_write) begin
         unique case (csr_index)
            msbb_pkg::CSR_RADIUS: radius_ff <= csr_data[3:0];
            msbb_pkg::CSR_ROWS:   rows_ff   <= csr_data;
            msbb_pkg::CSR_COLS:   cols_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      rows_c = (rows_ff == 7'd0) ? 8'd1 :
               ({1'b0, rows_ff} > 8'(msbb_pkg::MAX_ROWS)) ? 8'(msbb_pkg::MAX_ROWS)
                                                          : {1'b0, rows_ff};
      cols_c = (cols_ff == 7'd0) ? 8'd1 :
               ({1'b0, cols_ff} > 8'(msbb_pkg::MAX_COLS)) ? 8'(msbb_pkg::MAX_COLS)
                                                          : {1'b0, cols_ff};
      rad_c  = ({4'd0, radius_ff} > 8'(msbb_pkg::MAX_RADIUS)) ? 8'(msbb_pkg::MAX_RADIUS)
                                                            : {4'd0, radius_ff};
      lo_r = ({2'd0, in_data.row} < rad_c) ? 8'd0 : {2'd0, in_data.row} - rad_c;
      hi_r = ({2'd0, in_data.row} + rad_c > rows_c - 8'd1) ? rows_c - 8'd1
                                                           : {2'd0, in_data.row} + rad_c;
      lo_c = ({2'd0, in_data.col} < rad_c) ? 8'd0 : {2'd0, in_data.col} - rad_c;
      hi_c = ({2'd0, in_data.col} + rad_c > cols_c - 8'd1) ? cols_c - 8'd1
                                                           : {2'd0, in_data.col} + rad_c;
      cmd_in.is_load = (in_data.op == msbb_pkg::OP_LOAD);
      cmd_in.is_hole = ({2'd0, in_data.row} >= rows_c) || ({2'd0, in_data.col} >= cols_c);
      cmd_in.addr    = {in_data.row, in_data.col};
      cmd_in.value   = in_data.value;
      cmd_in.valid   = in_data.valid;
      cmd_in.r0 = lo_r[msbb_pkg::ROW_W-1:0];
      cmd_in.r1 = hi_r[msbb_pkg::ROW_W-1:0];
      cmd_in.c0 = lo_c[msbb_pkg::COL_W-1:0];
      cmd_in.c1 = hi_c[msbb_pkg::COL_W-1:0];
   end

   assign in_ready = !cmd_valid_ff || cmd_ready;

   always_ff @(posedge clock) begin
      if (reset) cmd_valid_ff <= 1'b0;
      else if (in_ready) cmd_valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) cmd_ff <= cmd_in;
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd_data  = cmd_ff;
endmodule

// ----- hdl/msbb_queue.sv -----
// short command queue between front and back end
module msbb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  msbb_pkg::cmd_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output msbb_pkg::cmd_type out_data
);
   msbb_pkg::cmd_type slots_ff [msbb_pkg::QUEUE_DEPTH];
   logic [msbb_pkg::QPTR_W-1:0] wr_ff, rd_ff;
   logic [msbb_pkg::QPTR_W:0]   count_ff;
   logic push, pop;

   assign in_ready  = (count_ff != (msbb_pkg::QPTR_W+1)'(msbb_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign out_data = slots_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + {{msbb_pkg::QPTR_W{1'b0}}, push}
                              - {{msbb_pkg::QPTR_W{1'b0}}, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ff] <= in_data;
   end
endmodule

// ----- hdl/msbb_divider.sv -----
// signed rounding divider, one quotient bit per cycle, ties away from zero
module msbb_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [msbb_pkg::SUM_W-1:0] dividend,
   input  logic [msbb_pkg::CNT_W-1:0]  divisor,
   output logic                        done,
   output logic [msbb_pkg::VAL_W-1:0]  quotient
);
   localparam int W = msbb_pkg::SUM_W;
   localparam int SW = $clog2(W + 1);
   msbb_pkg::div_state_type state_ff, state_in;
   logic [W-1:0] num_ff, quo_ff;
   logic [W-1:0] rem_ff;
   logic [msbb_pkg::CNT_W-1:0] den_ff;
   logic neg_ff;
   logic [SW-1:0] step_ff;
   logic [W-1:0] mag, trial;
   logic [W-1:0] rem_sh;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= msbb_pkg::DV_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         msbb_pkg::DV_IDLE: if (start) state_in = msbb_pkg::DV_RUN;
         msbb_pkg::DV_RUN:  if (step_ff == SW'(W - 1)) state_in = msbb_pkg::DV_DONE;
         msbb_pkg::DV_DONE: state_in = msbb_pkg::DV_IDLE;
         default: state_in = msbb_pkg::DV_IDLE;
      endcase
   end

   // |sum| + n/2 then restoring division
   assign mag = (dividend[W-1] ? W'(-dividend) : W'(dividend))
                + W'(divisor >> 1);
   assign rem_sh = {rem_ff[W-2:0], num_ff[W-1]};
   assign trial  = rem_sh - W'(den_ff);

   always_ff @(posedge clock) begin
      if (state_ff == msbb_pkg::DV_IDLE && start) begin
         num_ff <= mag;
         rem_ff <= '0;
         quo_ff <= '0;
         den_ff <= divisor;
         neg_ff <= dividend[W-1];
         step_ff <= '0;
      end else if (state_ff == msbb_pkg::DV_RUN) begin
         num_ff <= {num_ff[W-2:0], 1'b0};
         step_ff <= step_ff + 1'b1;
         if (rem_sh >= W'(den_ff)) begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[W-2:0], 1'b0};
         end
      end
   end

   assign done = (state_ff == msbb_pkg::DV_DONE);
   assign quotient = neg_ff ? msbb_pkg::VAL_W'(-quo_ff) : quo_ff[msbb_pkg::VAL_W-1:0];
endmodule

// ----- hdl/msbb_back.sv -----
// back end: grid memory, window sweep and result register
module msbb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  msbb_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [msbb_pkg::VAL_W-1:0] rsp_value,
   output logic              rsp_flag
);
   localparam int RW = msbb_pkg::ROW_W;
   localparam int CW = msbb_pkg::COL_W;
   localparam int VW = msbb_pkg::VAL_W;
   localparam int SW = msbb_pkg::SUM_W;
   localparam int NW = msbb_pkg::CNT_W;

   logic [VW:0] grid_mem [msbb_pkg::MAX_ROWS * msbb_pkg::MAX_COLS];
   logic [VW:0] rd_data_ff;

   msbb_pkg::back_state_type state_ff, state_in;
   msbb_pkg::cmd_type job_ff;
   logic [RW-1:0] row_ff;
   logic [CW-1:0] col_ff;
   logic rd_pend_ff, rd_last_ff;
   logic signed [SW-1:0] sum_ff, osum_ff;
   logic [NW-1:0] n_ff, on_ff;
   logic out_valid_ff;
   logic [VW-1:0] out_value_ff;
   logic out_flag_ff;

   logic div_start, div_done;
   logic signed [SW-1:0] div_num;
   logic [NW-1:0] div_den;
   logic [VW-1:0] div_q;

   logic take;
   logic last_read;

   assign take = cmd_valid && cmd_ready;
   assign cmd_ready = (state_ff == msbb_pkg::ST_IDLE) && !out_valid_ff;
   assign last_read = (row_ff == job_ff.r1);

   always_ff @(posedge clock) begin
      if (take && cmd_data.is_load) grid_mem[cmd_data.addr] <= {cmd_data.valid, cmd_data.value};
      rd_data_ff <= grid_mem[{row_ff, col_ff}];
   end

   msbb_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) state_ff <= msbb_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      div_start = 1'b0;
      div_num = sum_ff;
      div_den = n_ff;
      unique case (state_ff)
         msbb_pkg::ST_IDLE:
            if (take && !cmd_data.is_load) begin
               state_in = cmd_data.is_hole ? msbb_pkg::ST_SEND : msbb_pkg::ST_READ;
            end
         msbb_pkg::ST_READ:
            if (rd_pend_ff && rd_last_ff) begin
               if (n_ff != '0 || rd_data_ff[VW]) begin
                  state_in = msbb_pkg::ST_COL_DIV;
               end else if (col_ff == job_ff.c1) begin
                  state_in = msbb_pkg::ST_OUT_DIV;
               end
            end
         msbb_pkg::ST_COL_DIV: begin
            div_start = 1'b1;
            if (div_done) state_in = (col_ff == job_ff.c1) ? msbb_pkg::ST_OUT_DIV
                                                           : msbb_pkg::ST_READ;
         end
         msbb_pkg::ST_OUT_DIV:
            if (on_ff == '0) state_in = msbb_pkg::ST_SEND;
            else begin
               div_start = 1'b1;
               div_num = osum_ff;
               div_den = on_ff;
               if (div_done) state_in = msbb_pkg::ST_SEND;
            end
         msbb_pkg::ST_SEND: state_in = msbb_pkg::ST_IDLE;
         default: state_in = msbb_pkg::ST_IDLE;
      endcase
   end

   // one cell read issued per cycle while a column is swept, data back in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else if (take) begin
         job_ff <= cmd_data;
         row_ff <= cmd_data.r0;
         col_ff <= cmd_data.c0;
         sum_ff <= '0;
         n_ff <= '0;
         osum_ff <= '0;
         on_ff <= '0;
         rd_pend_ff <= 1'b0;
         rd_last_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            msbb_pkg::ST_READ: begin
               if (rd_pend_ff && rd_data_ff[VW]) begin
                  sum_ff <= sum_ff + SW'(signed'(rd_data_ff[VW-1:0]));
                  n_ff <= n_ff + 1'b1;
               end
               if (rd_pend_ff && rd_last_ff) begin
                  rd_pend_ff <= 1'b0;
                  rd_last_ff <= 1'b0;
                  if (n_ff == '0 && !rd_data_ff[VW] && col_ff != job_ff.c1) begin
                     col_ff <= col_ff + 1'b1;
                     row_ff <= job_ff.r0;
                  end
               end else if (!rd_last_ff) begin
                  rd_pend_ff <= 1'b1;
                  rd_last_ff <= last_read;
                  if (!last_read) row_ff <= row_ff + 1'b1;
               end
            end
            msbb_pkg::ST_COL_DIV:
               if (div_done) begin
                  osum_ff <= osum_ff + SW'(signed'(div_q));
                  on_ff <= on_ff + 1'b1;
                  sum_ff <= '0;
                  n_ff <= '0;
                  if (col_ff != job_ff.c1) begin
                     col_ff <= col_ff + 1'b1;
                     row_ff <= job_ff.r0;
                  end
               end
            default: ;
         endcase
      end
   end

   // output register holds the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (state_ff == msbb_pkg::ST_SEND) out_valid_ff <= 1'b1;
      else if (rsp_ready) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (state_ff == msbb_pkg::ST_OUT_DIV) begin
         if (on_ff == '0) begin
            out_value_ff <= '0;
            out_flag_ff <= 1'b0;
         end else if (div_done) begin
            out_value_ff <= div_q;
            out_flag_ff <= 1'b1;
         end
      end else if (take) begin
         out_value_ff <= '0;
         out_flag_ff <= 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;
   assign rsp_flag  = out_flag_ff;
endmodule

// ----- hdl/masked_separable_box_blur_top.sv -----
// top level of the masked separable box blur
// A load passes the front end register, the queue and the memory write. A query
// sweeps its clipped window one cell per cycle through the grid memory read
// port, column by column, pausing after each column that holds a valid cell for
// one bit-serial rounding division (a start state, 30 quotient bits and a done
// state); one more division gives the mean of the column means.
// The queue lets loads and queries be accepted while a query is being worked.
// Only one query is in the back end at a time; its result waits in an output
// register until taken. Unwritten cells read as anything.
module masked_separable_box_blur_top (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [msbb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [msbb_pkg::CSR_W-1:0] csr_data,
   msbb_req_if.sink   req,
   msbb_rsp_if.source rsp
);
   // front to queue
   logic f_valid, f_ready;
   msbb_pkg::cmd_type f_data;
   // queue to back
   logic b_valid, b_ready;
   msbb_pkg::cmd_type b_data;

   msbb_front u_front (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data)
   );

   msbb_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   msbb_back u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd_data(b_data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_value(rsp.blurred_value), .rsp_flag(rsp.blurred_valid)
   );

   // a hole result always carries a zero value
   a_hole_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.blurred_valid |-> rsp.blurred_value == '0)
      else $error("hole result with nonzero value");

   // back end takes nothing while a result is waiting
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !b_ready)
      else $error("back end ready while result waits");

   // a waiting result holds until transfer
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.blurred_value))
      else $error("result changed before transfer");
endmodule

// ----- sim/tb.sv -----
// self-checking testbench for the masked separable box blur
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_CELLS = msbb_pkg::MAX_ROWS * msbb_pkg::MAX_COLS;
   localparam int N_PHASES   = 6;
   // random items per phase, the wide-radius phase kept short as it is slow
   localparam int PHASE_ITEMS [N_PHASES] = '{180, 160, 40, 150, 170, 180};
   localparam int STIM_TOTAL = 1350;
   // random queries land in this corner
   localparam int REGION     = 16;
   localparam int LOAD_SPAN  = 22;
   localparam int DRAIN_CYCLES = 2400;
   localparam int HOLD_CYCLES  = 4000;
   localparam longint CYCLE_LIMIT = 6000000;

   typedef struct {
      logic [msbb_pkg::VAL_W-1:0] value;
      logic                       valid;
   } blur_result_type;

   // keeps its own copy of grid and registers and the results still owed
   class blur_scoreboard_type;
      logic [msbb_pkg::VAL_W:0] cells [GRID_CELLS];
      bit                       written [GRID_CELLS];
      int unsigned              radius_reg;
      int unsigned              rows_reg;
      int unsigned              cols_reg;
      blur_result_type          owed_q [$];
      int                       errors;

      function new();
         radius_reg = 1;
         rows_reg   = 64;
         cols_reg   = 64;
         errors     = 0;
         foreach (cells[i]) cells[i] = '0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      function void set_reg(logic [msbb_pkg::CSR_IDX_W-1:0] idx,
                            logic [msbb_pkg::CSR_W-1:0] d);
         case (idx)
            msbb_pkg::CSR_RADIUS: radius_reg = d[3:0];
            msbb_pkg::CSR_ROWS:   rows_reg   = d;
            msbb_pkg::CSR_COLS:   cols_reg   = d;
            default: ;
         endcase
      endfunction

      static function longint round_mean(longint s, longint n);
         if (s >= 0) return (s + n / 2) / n;
         return -((-s + n / 2) / n);
      endfunction

      // clipped window of a query, 0 when the query lies outside the area in use
      function bit get_window(input int row, input int col, output int r0,
                              output int r1, output int c0, output int c1);
         int rows, cols, rad;
         r0 = 0;
         r1 = 0;
         c0 = 0;
         c1 = 0;
         rows = (rows_reg == 0) ? 1 :
                ((rows_reg > msbb_pkg::MAX_ROWS) ? msbb_pkg::MAX_ROWS : rows_reg);
         cols = (cols_reg == 0) ? 1 :
                ((cols_reg > msbb_pkg::MAX_COLS) ? msbb_pkg::MAX_COLS : cols_reg);
         rad  = (radius_reg > msbb_pkg::MAX_RADIUS) ? msbb_pkg::MAX_RADIUS : radius_reg;
         if (row >= rows || col >= cols) return 1'b0;
         r0 = (row - rad < 0) ? 0 : row - rad;
         r1 = (row + rad > rows - 1) ? rows - 1 : row + rad;
         c0 = (col - rad < 0) ? 0 : col - rad;
         c1 = (col + rad > cols - 1) ? cols - 1 : col + rad;
         return 1'b1;
      endfunction

      // first never-loaded cell in the window of a query, -1 when there is none
      function int first_gap(int row, int col);
         int r0, r1, c0, c1;
         if (!get_window(row, col, r0, r1, c0, c1)) return -1;
         for (int c = c0; c <= c1; c++)
            for (int r = r0; r <= r1; r++)
               if (!written[r * msbb_pkg::MAX_COLS + c]) return r * msbb_pkg::MAX_COLS + c;
         return -1;
      endfunction

      function blur_result_type blur_at(int row, int col);
         blur_result_type res;
         int r0, r1, c0, c1;
         longint outer_sum, outer_n, col_sum, col_n;
         logic [msbb_pkg::VAL_W:0] cell_word;
         res.value = '0;
         res.valid = 1'b0;
         if (!get_window(row, col, r0, r1, c0, c1)) return res;
         outer_sum = 0;
         outer_n   = 0;
         for (int c = c0; c <= c1; c++) begin
            col_sum = 0;
            col_n   = 0;
            for (int r = r0; r <= r1; r++) begin
               cell_word = cells[r * msbb_pkg::MAX_COLS + c];
               if (cell_word[msbb_pkg::VAL_W]) begin
                  col_sum += longint'($signed(cell_word[msbb_pkg::VAL_W-1:0]));
                  col_n++;
               end
            end
            if (col_n > 0) begin
               outer_sum += round_mean(col_sum, col_n);
               outer_n++;
            end
         end
         if (outer_n > 0) begin
            res.value = msbb_pkg::VAL_W'(round_mean(outer_sum, outer_n));
            res.valid = 1'b1;
         end
         return res;
      endfunction

      function void note_input(msbb_pkg::req_type it);
         if (it.op == msbb_pkg::OP_LOAD) begin
            cells[it.row * msbb_pkg::MAX_COLS + it.col] = {it.valid, it.value};
            written[it.row * msbb_pkg::MAX_COLS + it.col] = 1'b1;
         end else begin
            owed_q.push_back(blur_at(it.row, it.col));
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check(logic [msbb_pkg::VAL_W-1:0] v, logic ok);
         blur_result_type exp_res;
         if (owed_q.size() == 0) begin
            report($sformatf("result %h/%b with none owed", v, ok));
            return;
         end
         exp_res = owed_q.pop_front();
         if (ok !== exp_res.valid)
            report($sformatf("blurred_valid %b, want %b", ok, exp_res.valid));
         if (v !== exp_res.value)
            report($sformatf("blurred_value %h, want %h", v, exp_res.value));
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_write;
   logic [msbb_pkg::CSR_IDX_W-1:0] csr_index;
   logic [msbb_pkg::CSR_W-1:0] csr_data;

   msbb_req_if req ();
   msbb_rsp_if rsp ();

   masked_separable_box_blur_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req       (req.sink),
      .rsp       (rsp.source)
   );

   blur_scoreboard_type sb = new();

   int items_done = 0;   // every accepted transfer, window loads included
   bit hold_req   = 0;   // asks the receiver for one long hold-off
   int hold_left  = 0;

   // idling mode: first third, then swapped, then none
   function automatic int idle_mode();
      return items_done * 3 / STIM_TOTAL;
   endfunction

   function automatic int sender_idle_pct();
      case (idle_mode())
         0: return 36;
         1: return 86;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (idle_mode())
         0: return 86;
         1: return 36;
         default: return 0;
      endcase
   endfunction

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on total run length
   initial begin
      for (longint n = 0; n < CYCLE_LIMIT; n++) @(posedge clock);
      $display("tb failed");
      $finish;
   end

   // one transfer on the request channel, with random idle cycles first
   task automatic send_item(msbb_pkg::req_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct()) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid = 1'b1;
      req.data  = it;
      do @(posedge clock); while (!req.ready);
      sb.note_input(it);
      items_done++;
      // one long receiver stall early on
      if (items_done == 150) hold_req = 1;
   endtask

   function automatic logic [msbb_pkg::VAL_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return msbb_pkg::VAL_W'($urandom_range(0, 7));
         default: return msbb_pkg::VAL_W'($urandom);
      endcase
   endfunction

   task automatic load_cell(int row, int col, logic [msbb_pkg::VAL_W-1:0] v, logic ok);
      msbb_pkg::req_type it;
      it.op    = msbb_pkg::OP_LOAD;
      it.row   = msbb_pkg::ROW_W'(row);
      it.col   = msbb_pkg::COL_W'(col);
      it.value = v;
      it.valid = ok;
      send_item(it);
   endtask

   task automatic query_cell(int row, int col);
      msbb_pkg::req_type it;
      int gap;
      // cells of the window that were never loaded get a value first
      gap = sb.first_gap(row, col);
      while (gap >= 0) begin
         load_cell(gap / msbb_pkg::MAX_COLS, gap % msbb_pkg::MAX_COLS, random_value(),
                   $urandom_range(0, 3) != 0);
         gap = sb.first_gap(row, col);
      end
      it.op    = msbb_pkg::OP_QUERY;
      it.row   = msbb_pkg::ROW_W'(row);
      it.col   = msbb_pkg::COL_W'(col);
      it.value = msbb_pkg::VAL_W'($urandom);
      it.valid = 1'($urandom);
      send_item(it);
   endtask

   task automatic write_csr(logic [msbb_pkg::CSR_IDX_W-1:0] idx,
                            logic [msbb_pkg::CSR_W-1:0] d);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = d;
      sb.set_reg(idx, d);
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // registers only change once every owed result is back and loads have settled
   task automatic wait_idle();
      @(negedge clock);
      req.valid = 1'b0;
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_item();
      int span;
      span = ($urandom_range(0, 3) == 0) ? msbb_pkg::MAX_ROWS : LOAD_SPAN;
      if ($urandom_range(0, 1))
         query_cell($urandom_range(0, REGION - 1), $urandom_range(0, REGION - 1));
      else
         load_cell($urandom_range(0, span - 1), $urandom_range(0, span - 1),
                   random_value(), $urandom_range(0, 3) != 0);
   endtask

   // receiver: samples at the rising edge, moves ready at the falling edge
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready) sb.check(rsp.blurred_value, rsp.blurred_valid);
         @(negedge clock);
         if (hold_req) begin
            hold_req  = 0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready = 1'b0;
         end else begin
            rsp.ready = ($urandom_range(0, 99) >= receiver_idle_pct());
         end
      end
   end

   // main sequence
   initial begin
      // register settings per random phase: radius, rows in use, columns in use
      logic [msbb_pkg::CSR_W-1:0] phase_cfg [N_PHASES][3];
      phase_cfg = '{'{7'd3,  7'd64,  7'd64},
                    '{7'd0,  7'd0,   7'd127},
                    '{7'd15, 7'd20,  7'd20},
                    '{7'd2,  7'd1,   7'd1},
                    '{7'd5,  7'd100, 7'd33},
                    '{7'd1,  7'd64,  7'd64}};
      reset     = 1'b1;
      csr_write = 1'b0;
      csr_index = msbb_pkg::CSR_RADIUS;
      csr_data  = '0;
      req.valid = 1'b0;
      req.data  = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // directed part at reset settings (radius 1, full grid)
      // rounding ties in both signs: columns of 1,2 and -1,-2
      load_cell(0, 0, 24'd1, 1'b1);
      load_cell(1, 0, 24'd2, 1'b1);
      load_cell(0, 1, -24'sd1, 1'b1);
      load_cell(1, 1, -24'sd2, 1'b1);
      query_cell(0, 0);
      // window made only of holes gives a hole
      load_cell(62, 62, 24'h123456, 1'b0);
      load_cell(62, 63, 24'h7FFFFF, 1'b0);
      load_cell(63, 62, 24'h800000, 1'b0);
      load_cell(63, 63, 24'h000001, 1'b0);
      query_cell(63, 63);
      // field extremes
      load_cell(0, 63, 24'h7FFFFF, 1'b1);
      load_cell(1, 63, 24'h7FFFFF, 1'b1);
      query_cell(0, 63);
      load_cell(63, 0, 24'h800000, 1'b1);
      load_cell(62, 0, 24'h800000, 1'b1);
      query_cell(63, 0);
      query_cell(31, 32);
      query_cell(62, 1);
      query_cell(1, 62);
      query_cell(32, 31);

      for (int p = 0; p < N_PHASES; p++) begin
         wait_idle();
         write_csr(msbb_pkg::CSR_RADIUS, phase_cfg[p][0]);
         write_csr(msbb_pkg::CSR_ROWS,   phase_cfg[p][1]);
         write_csr(msbb_pkg::CSR_COLS,   phase_cfg[p][2]);
         for (int i = 0; i < PHASE_ITEMS[p]; i++) random_item();
      end

      // drain, then allow for the last query to finish
      wait_idle();
      if (sb.errors == 0 && sb.owed_q.size() == 0) begin
         $display("tb passed");
      end else begin
         if (sb.owed_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.owed_q.size()));
         $display("tb failed");
      end
      $finish;
   end
endmodule

// ----- masked_separable_box_blur_top.f -----
hdl/msbb_pkg.sv
hdl/msbb_if.sv
hdl/msbb_front.sv
hdl/msbb_queue.sv
hdl/msbb_divider.sv
hdl/msbb_back.sv
hdl/masked_separable_box_blur_top.sv
sim/tb.sv
